// ----- sv/ordered_list_append_delete_assert.svh -----
// Assertion macros for the ordered list block.
// Used by modules that have clk and rst in scope; no other dependencies.
`ifndef ORDERED_LIST_APPEND_DELETE_ASSERT_SVH
`define ORDERED_LIST_APPEND_DELETE_ASSERT_SVH

// Checked on every rising edge outside reset.
`define OLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define OLA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/ola_pkg.sv -----
// Shared types and constants for the ordered list block.
// No dependencies; the interface, cell, chain and top-level files refer to it by scoped names.
package ola_pkg;

  localparam int VALUE_W          = 32;
  localparam int ENTRY_COUNT_W    = 7;
  localparam int CAPACITY_DEFAULT = 64;

  // Operation carried in the mode field.
  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_APPENDED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_NOMATCH  = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic {
    SEQ_IDLE   = 1'b0,
    SEQ_DELETE = 1'b1
  } seq_state_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;   // every cell takes its upper neighbor's value
    logic wr_en;   // the addressed cell takes the write data
  } cell_ctl_t;

endpackage

// ----- sv/ola_if.sv -----
// Valid/ready channel interfaces for request and response beats.
// Depends on ola_pkg for the payload widths.
interface ola_req_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [ola_pkg::VALUE_W-1:0]  item_value;

  modport source (output valid, output mode, output item_value, input ready);
  modport sink   (input valid, input mode, input item_value, output ready);
endinterface

interface ola_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic [ola_pkg::VALUE_W-1:0]        echo_value;
  logic [ola_pkg::ENTRY_COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output echo_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input echo_value, input entry_count,
                  output ready);
endinterface

// ----- sv/ola_cell.sv -----
// One storage cell of the list chain: holds a single value.
// Depends on ola_pkg for the control struct and value width.
module ola_cell #(
  parameter int IDX_W = 6,
  parameter int INDEX = 0
) (
  input  logic                         clk,
  input  ola_pkg::cell_ctl_t           ctl,
  input  logic [IDX_W-1:0]             wr_pos,
  input  logic [ola_pkg::VALUE_W-1:0]  wr_data,
  input  logic [ola_pkg::VALUE_W-1:0]  nb_value,
  output logic [ola_pkg::VALUE_W-1:0]  value
);

  logic [ola_pkg::VALUE_W-1:0] stored;

  // A direct write wins over the shift from the neighbor.
  always_ff @(posedge clk) begin
    if (ctl.wr_en && (wr_pos == IDX_W'(INDEX))) begin
      stored <= wr_data;
    end else if (ctl.shift) begin
      stored <= nb_value;
    end
  end

  assign value = stored;

endmodule

// ----- sv/ola_chain.sv -----
// Row of storage cells; each cell hands its value to the cell below it on a shift.
// Depends on ola_pkg and ola_cell.
module ola_chain #(
  parameter int CAPACITY = ola_pkg::CAPACITY_DEFAULT,
  parameter int IDX_W    = 6
) (
  input  logic                         clk,
  input  ola_pkg::cell_ctl_t           ctl,
  input  logic [IDX_W-1:0]             wr_pos,
  input  logic [ola_pkg::VALUE_W-1:0]  wr_data,
  output logic [ola_pkg::VALUE_W-1:0]  head
);

  logic [ola_pkg::VALUE_W-1:0] cell_value [CAPACITY];

  // The top cell takes the head value, which closes the chain into a ring.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ola_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .wr_pos   (wr_pos),
      .wr_data  (wr_data),
      .nb_value (cell_value[(i + 1) % CAPACITY]),
      .value    (cell_value[i])
    );
  end

  assign head = cell_value[0];

endmodule

// ----- sv/ordered_list_append_delete.sv -----
// Ordered list with append and delete-all, kept in a chain of value cells.
// Results: an append's result beat is registered and shown in the cycle after acceptance; a
// delete walks the held entries, one cell shift per entry, and then gives its result beat.
// Flow: one item at a time; a new request is taken only when idle and the result slot is free or draining.
// Reset: rst (synchronous) empties the list, returns to idle and clears the result valid flag; the cell
// contents are left as they are and are only read below the entry count.
module ordered_list_append_delete #(
  parameter int CAPACITY = ola_pkg::CAPACITY_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  ola_req_if.sink          req,
  ola_rsp_if.source        rsp
);

  `include "ordered_list_append_delete_assert.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  ola_pkg::seq_state_t state, state_next;

  logic [CNT_W-1:0]            count, count_next;
  logic [CNT_W-1:0]            len, len_next;
  logic [CNT_W-1:0]            rd_left, rd_left_next;
  logic                        hit, hit_next;
  logic [ola_pkg::VALUE_W-1:0] target, target_next;

  logic                        out_valid, out_valid_next;
  ola_pkg::status_t            out_status, out_status_next;
  logic [ola_pkg::VALUE_W-1:0] out_echo, out_echo_next;
  logic [CNT_W-1:0]            out_count, out_count_next;

  ola_pkg::cell_ctl_t          ctl;
  logic [IDX_W-1:0]            wr_pos;
  logic [ola_pkg::VALUE_W-1:0] wr_data;
  logic [ola_pkg::VALUE_W-1:0] head;
  logic                        accept;
  logic                        head_match;
  logic [CNT_W-1:0]            len_m1;
  logic [CNT_W+ola_pkg::ENTRY_COUNT_W-1:0] count_ext;

  ola_chain #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .wr_pos  (wr_pos),
    .wr_data (wr_data),
    .head    (head)
  );

  // A new beat is taken only when idle and the result slot is free or draining.
  assign req.ready  = (state == ola_pkg::SEQ_IDLE) && (!out_valid || rsp.ready);
  assign accept     = req.valid && req.ready;
  assign head_match = (head == target);
  assign len_m1     = len - CNT_W'(1);

  // Sequencer: appends and deletes on an empty list finish at once, other deletes rotate the held entries once.
  always_comb begin
    state_next      = state;
    count_next      = count;
    len_next        = len;
    rd_left_next    = rd_left;
    hit_next        = hit;
    target_next     = target;
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_echo_next   = out_echo;
    out_count_next  = out_count;
    ctl             = '0;
    wr_pos          = count[IDX_W-1:0];
    wr_data         = req.item_value;

    case (state)
      ola_pkg::SEQ_IDLE: begin
        if (accept) begin
          out_echo_next = req.item_value;
          target_next   = req.item_value;
          if (req.mode == ola_pkg::MODE_APPEND) begin
            out_valid_next = 1'b1;
            if (count < CNT_W'(CAPACITY)) begin
              ctl.wr_en       = 1'b1;
              count_next      = count + CNT_W'(1);
              out_status_next = ola_pkg::ST_APPENDED;
              out_count_next  = count + CNT_W'(1);
            end else begin
              out_status_next = ola_pkg::ST_FULL;
              out_count_next  = count;
            end
          end else if (count == '0) begin
            // Nothing held: no pass over the chain is needed.
            out_valid_next  = 1'b1;
            out_status_next = ola_pkg::ST_NOMATCH;
            out_count_next  = count;
          end else begin
            state_next   = ola_pkg::SEQ_DELETE;
            len_next     = count;
            rd_left_next = count;
            hit_next     = 1'b0;
          end
        end
      end
      ola_pkg::SEQ_DELETE: begin
        // Pop the head; a kept value goes back in behind the rest of the list.
        ctl.shift    = 1'b1;
        ctl.wr_en    = !head_match;
        wr_pos       = len_m1[IDX_W-1:0];
        wr_data      = head;
        len_next     = head_match ? len_m1 : len;
        hit_next     = hit || head_match;
        rd_left_next = rd_left - CNT_W'(1);
        if (rd_left == CNT_W'(1)) begin
          state_next      = ola_pkg::SEQ_IDLE;
          count_next      = len_next;
          out_valid_next  = 1'b1;
          out_status_next = hit_next ? ola_pkg::ST_REMOVED : ola_pkg::ST_NOMATCH;
          out_count_next  = len_next;
        end
      end
      default: begin
        state_next = ola_pkg::SEQ_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ola_pkg::SEQ_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    len        <= len_next;
    rd_left    <= rd_left_next;
    hit        <= hit_next;
    target     <= target_next;
    out_status <= out_status_next;
    out_echo   <= out_echo_next;
    out_count  <= out_count_next;
  end

  // The count field carries the low bits of the number held.
  assign count_ext       = {{ola_pkg::ENTRY_COUNT_W{1'b0}}, out_count};
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.echo_value  = out_echo;
  assign rsp.entry_count = count_ext[ola_pkg::ENTRY_COUNT_W-1:0];

  `OLA_ASSERT(a_count_bound, count <= CNT_W'(CAPACITY), "entry count exceeds capacity")
  `OLA_ASSERT(a_len_covers_left, (state == ola_pkg::SEQ_DELETE) |-> (len >= rd_left && rd_left != '0), "delete pass lost track of the list length")
  `OLA_ASSERT(a_ready_only_idle, req.ready |-> (state == ola_pkg::SEQ_IDLE), "request taken during a delete pass")
  `OLA_ASSERT(a_append_grows, (accept && req.mode == ola_pkg::MODE_APPEND && count < CNT_W'(CAPACITY)) |=> (count == $past(count) + CNT_W'(1)), "append did not add one entry")
  `OLA_ASSERT(a_delete_shrinks, (state == ola_pkg::SEQ_DELETE && rd_left == CNT_W'(1)) |=> (count <= $past(count) && out_valid), "delete pass ended badly")
  `OLA_ASSERT_ALWAYS(a_reset_clears, rst |=> (count == '0 && !out_valid && state == ola_pkg::SEQ_IDLE), "reset did not empty the list")

endmodule
